/* rtl/core/tcfs_pkg.sv */
// Shared types, constants and helper functions for the texture combiner.
package tcfs_pkg;

    localparam int unsigned NUM_STAGE_SLOTS = 4;
    localparam int unsigned SETUP_W = 54;
    localparam int unsigned CTRL_W = 28;

    // register map indexes
    typedef enum logic [2:0] {
        REG_CONTROL = 3'd0,
        REG_RASTER  = 3'd1,
        REG_KONST_LO = 3'd2,
        REG_KONST_HI = 3'd3,
        REG_STAGE0  = 3'd4,
        REG_STAGE1  = 3'd5,
        REG_STAGE2  = 3'd6,
        REG_STAGE3  = 3'd7
    } reg_index_t;

    // alpha compare codes
    typedef enum logic [2:0] {
        CMP_NEVER   = 3'd0,
        CMP_LESS    = 3'd1,
        CMP_EQUAL   = 3'd2,
        CMP_LEQUAL  = 3'd3,
        CMP_GREATER = 3'd4,
        CMP_NEQUAL  = 3'd5,
        CMP_GEQUAL  = 3'd6,
        CMP_ALWAYS  = 3'd7
    } cmp_code_t;

    typedef enum logic [1:0] {
        LOP_AND  = 2'd0,
        LOP_OR   = 2'd1,
        LOP_XOR  = 2'd2,
        LOP_XNOR = 2'd3
    } logic_op_t;

    // color input selects
    localparam logic [3:0] CSEL_TEX_C  = 4'd8;
    localparam logic [3:0] CSEL_TEX_A  = 4'd9;
    localparam logic [3:0] CSEL_RAS_C  = 4'd10;
    localparam logic [3:0] CSEL_RAS_A  = 4'd11;
    localparam logic [3:0] CSEL_ONE    = 4'd12;
    localparam logic [3:0] CSEL_HALF   = 4'd13;
    localparam logic [3:0] CSEL_KONST  = 4'd14;
    // alpha input selects
    localparam logic [2:0] ASEL_TEX   = 3'd4;
    localparam logic [2:0] ASEL_RAS   = 3'd5;
    localparam logic [2:0] ASEL_KONST = 3'd6;

    localparam logic signed [10:0] VAL_MIN = -11'sd1024;
    localparam logic signed [10:0] VAL_MAX = 11'sd1023;

    typedef logic signed [10:0] val_t;

    // one pixel moving through the chain: four registers of RGBA
    typedef struct packed {
        val_t [3:0][3:0] regs;     // [reg][channel]
        logic [3:0][7:0] tex;
        logic [1:0]      lastc;
        logic [1:0]      lasta;
    } pix_t;

    // per-stage configuration bundle handed to each cell
    typedef struct packed {
        logic            enable;
        logic [SETUP_W-1:0] setup;
        logic [31:0]     raster;
        logic [63:0]     konst_lo;
        logic [63:0]     konst_hi;
    } cell_cfg_t;

    function automatic logic [7:0] konst_fixed(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'd255;
            3'd1: v = 8'd223;
            3'd2: v = 8'd191;
            3'd3: v = 8'd159;
            3'd4: v = 8'd128;
            3'd5: v = 8'd96;
            3'd6: v = 8'd64;
            default: v = 8'd32;
        endcase
        return v;
    endfunction

    function automatic logic signed [8:0] bias_value(input logic [1:0] b);
        logic signed [8:0] v;
        case (b)
            2'd1: v = 9'sd128;
            2'd2: v = -9'sd128;
            default: v = 9'sd0;
        endcase
        return v;
    endfunction

    function automatic logic cmp_alpha(input val_t a, input logic [2:0] code,
                                       input logic [7:0] ref_val);
        logic signed [11:0] x;
        logic signed [11:0] r;
        logic res;
        x = 12'(a);
        r = $signed({4'd0, ref_val});
        case (cmp_code_t'(code))
            CMP_NEVER:   res = 1'b0;
            CMP_LESS:    res = x < r;
            CMP_EQUAL:   res = x == r;
            CMP_LEQUAL:  res = x <= r;
            CMP_GREATER: res = x > r;
            CMP_NEQUAL:  res = x != r;
            CMP_GEQUAL:  res = x >= r;
            default:     res = 1'b1;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] clamp_byte(input val_t v);
        logic [7:0] r;
        if (v < 0)
            r = 8'd0;
        else if (v > 11'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

/* rtl/core/tcfs_stream_if.sv */
// Valid/ready channel carrying one RGBA beat.
interface tcfs_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;

    modport source (output valid, output red, output green, output blue,
                    output alpha, input ready);
    modport sink (input valid, input red, input green, input blue,
                  input alpha, output ready);
endinterface

/* rtl/core/texture_combiner_four_stage.sv */
// Texture combiner: up to four chained stages evaluated one per cell in a pipeline, one texel
// per clock while the output is taken. Each stage cell registers its pixel and an output
// register holds the alpha-tested, byte-clamped result, so up to MAX_STAGES+1 beats are in
// flight. Stages beyond the programmed count pass the pixel through unchanged. The chain
// stalls as a whole when the output is not taken; configuration must be written only while
// no beat is in flight.
module texture_combiner_four_stage #(
    parameter int unsigned MAX_STAGES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    tcfs_stream_if.sink   tex,
    tcfs_stream_if.source pix
);

    logic [27:0] control_reg;
    logic [31:0] raster_reg;
    logic [63:0] konst_lo_reg;
    logic [63:0] konst_hi_reg;
    logic [tcfs_pkg::NUM_STAGE_SLOTS-1:0][53:0] setup_reg;
    logic [2:0]  idx;
    logic        wr_en;
    logic [2:0]  count;
    logic        advance;
    logic        out_valid_reg;
    logic [3:0][7:0] out_reg;
    logic [3:0][7:0] out_next;

    logic           cv [MAX_STAGES+1];
    tcfs_pkg::pix_t cp [MAX_STAGES+1];

    assign pready = 1'b1;
    assign idx = paddr[5:3];
    assign wr_en = psel && penable && pwrite;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg <= '0;
            raster_reg <= '0;
            konst_lo_reg <= '0;
            konst_hi_reg <= '0;
            setup_reg <= '0;
        end
        else if (wr_en)
        begin
            case (tcfs_pkg::reg_index_t'(idx))
                tcfs_pkg::REG_CONTROL:  control_reg <= pwdata[27:0];
                tcfs_pkg::REG_RASTER:   raster_reg <= pwdata[31:0];
                tcfs_pkg::REG_KONST_LO: konst_lo_reg <= pwdata;
                tcfs_pkg::REG_KONST_HI: konst_hi_reg <= pwdata;
                default:                setup_reg[idx[1:0]] <= pwdata[53:0];
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (tcfs_pkg::reg_index_t'(idx))
            tcfs_pkg::REG_CONTROL:  prdata = 64'(control_reg);
            tcfs_pkg::REG_RASTER:   prdata = 64'(raster_reg);
            tcfs_pkg::REG_KONST_LO: prdata = konst_lo_reg;
            tcfs_pkg::REG_KONST_HI: prdata = konst_hi_reg;
            default:                prdata = 64'(setup_reg[idx[1:0]]);
        endcase
    end

    // saturate stage count
    assign count = (control_reg[2:0] > 3'(MAX_STAGES)) ? 3'(MAX_STAGES) : control_reg[2:0];

    // chain stalls only when the output holds an untaken beat
    assign advance = !out_valid_reg || pix.ready;
    assign tex.ready = advance;

    // feed the first cell straight from the input channel
    assign cv[0] = tex.valid;
    assign cp[0].regs = '0;
    assign cp[0].tex = {tex.alpha, tex.blue, tex.green, tex.red};
    assign cp[0].lastc = '0;
    assign cp[0].lasta = '0;

    for (genvar s = 0; s < MAX_STAGES; s++)
    begin : g_cell
        tcfs_pkg::cell_cfg_t ccfg;
        assign ccfg.enable = 3'(s) < count;
        assign ccfg.setup = setup_reg[s];
        assign ccfg.raster = raster_reg;
        assign ccfg.konst_lo = konst_lo_reg;
        assign ccfg.konst_hi = konst_hi_reg;
        tcfs_cell u_cell (
            .clk(clk), .rst_n(rst_n), .advance(advance),
            .in_valid(cv[s]), .in_pix(cp[s]), .cfg(ccfg),
            .out_valid(cv[s+1]), .out_pix(cp[s+1])
        );
    end

    // final selection, alpha test and byte clamp
    always_comb
    begin
        tcfs_pkg::pix_t p;
        tcfs_pkg::val_t [3:0] r;
        logic l;
        logic rr;
        logic pass;
        p = cp[MAX_STAGES];
        for (int ch = 0; ch < 3; ch++)
            r[ch] = p.regs[p.lastc][ch];
        r[3] = p.regs[p.lasta][3];
        l = tcfs_pkg::cmp_alpha(r[3], control_reg[6:4], control_reg[14:7]);
        rr = tcfs_pkg::cmp_alpha(r[3], control_reg[17:15], control_reg[25:18]);
        case (tcfs_pkg::logic_op_t'(control_reg[27:26]))
            tcfs_pkg::LOP_OR:   pass = l || rr;
            tcfs_pkg::LOP_XOR:  pass = l != rr;
            tcfs_pkg::LOP_XNOR: pass = l == rr;
            default:            pass = l && rr;
        endcase
        if (count == 3'd0)
            out_next = p.tex;
        else
        begin
            for (int ch = 0; ch < 4; ch++)
                out_next[ch] = (control_reg[3] && !pass) ? 8'd0
                               : tcfs_pkg::clamp_byte(r[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= cv[MAX_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    assign pix.valid = out_valid_reg;
    assign pix.red = out_reg[0];
    assign pix.green = out_reg[1];
    assign pix.blue = out_reg[2];
    assign pix.alpha = out_reg[3];

    // output beat holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pix.ready |=> out_valid_reg && $stable(out_reg))
        else $error("output beat changed while stalled");

    // input is taken exactly when the chain advances
    assert property (@(posedge clk) disable iff (!rst_n)
        tex.ready == (!out_valid_reg || pix.ready))
        else $error("input ready out of step with chain");

    // last cell valid reaches the output on advance
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && cv[MAX_STAGES] |=> out_valid_reg)
        else $error("pixel lost at output");

endmodule

/* rtl/core/tcfs_combine.sv */
// Combiner arithmetic for one channel: d +/- lerp(a, b, c), bias, scale, clamp.
module tcfs_combine
(
    input  logic                   sub,
    input  logic [1:0]             bias,
    input  logic [1:0]             scale,
    input  logic                   clamp8,
    input  tcfs_pkg::val_t         a,
    input  tcfs_pkg::val_t         b,
    input  tcfs_pkg::val_t         c,
    input  tcfs_pkg::val_t         d,
    output tcfs_pkg::val_t         res
);

    logic signed [11:0] c256;
    logic signed [12:0] one_minus;
    logic signed [25:0] prod;
    logic signed [27:0] t_scaled;
    logic signed [19:0] t_shr;
    logic signed [19:0] t_sgn;
    logic signed [13:0] d_bias;
    logic signed [20:0] r_sum;
    logic signed [20:0] r_out;
    logic [1:0]         ls;

    always_comb
    begin
        ls = (scale == 2'd1) ? 2'd1 : ((scale == 2'd2) ? 2'd2 : 2'd0);
        // c expanded so 255 maps to 256
        c256 = 12'(c) + 12'(c >>> 7);
        one_minus = 13'sd256 - 13'(c256);
        prod = 26'(a) * 26'(one_minus) + 26'(b) * 26'(c256);
        t_scaled = 28'(prod) <<< ls;
        if (scale != 2'd3)
            t_scaled = t_scaled + (sub ? 28'sd127 : 28'sd128);
        t_shr = 20'(t_scaled >>> 8);
        t_sgn = sub ? -t_shr : t_shr;
        d_bias = 14'(d) + 14'(tcfs_pkg::bias_value(bias));
        r_sum = (21'(d_bias) <<< ls) + 21'(t_sgn);
        r_out = (scale == 2'd3) ? (r_sum >>> 1) : r_sum;
        // clamp to byte or to the signed 11-bit range
        if (clamp8)
        begin
            if (r_out < 0)
                res = '0;
            else if (r_out > 21'sd255)
                res = 11'sd255;
            else
                res = 11'(r_out);
        end
        else
        begin
            if (r_out < 21'(tcfs_pkg::VAL_MIN))
                res = tcfs_pkg::VAL_MIN;
            else if (r_out > 21'(tcfs_pkg::VAL_MAX))
                res = tcfs_pkg::VAL_MAX;
            else
                res = 11'(r_out);
        end
    end

endmodule

/* rtl/core/tcfs_cell.sv */
// One combiner stage cell: evaluates a stage and registers the pixel onward.
module tcfs_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  tcfs_pkg::pix_t      in_pix,
    input  tcfs_pkg::cell_cfg_t cfg,
    output logic                out_valid,
    output tcfs_pkg::pix_t      out_pix
);

    logic                  valid_reg;
    tcfs_pkg::pix_t        pix_reg;
    tcfs_pkg::pix_t        pix_next;
    logic [53:0]           st;
    logic [3:0][7:0]       ras;
    logic [3:0][7:0]       kc;
    logic [3:0][7:0]       ka;
    logic [3:0][7:0]       kon;
    tcfs_pkg::val_t [2:0][3:0] carg;
    tcfs_pkg::val_t [3:0]  aarg;
    tcfs_pkg::val_t [2:0]  cres;
    tcfs_pkg::val_t        ares;

    function automatic logic [7:0] kchan(input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [1:0] col, input logic [1:0] ch);
        logic [63:0] w;
        w = col[1] ? hi : lo;
        return w[{col[0], ch, 3'd0} +: 8];
    endfunction

    function automatic logic [3:0][7:0] kvec(input logic [4:0] sel,
                                              input logic [63:0] lo,
                                              input logic [63:0] hi);
        logic [3:0][7:0] k;
        logic [7:0]      v;
        v = '0;
        k = '0;
        if (sel < 5'd8)
            v = tcfs_pkg::konst_fixed(sel[2:0]);
        else if (sel >= 5'd16)
            v = kchan(lo, hi, sel[1:0], sel[3:2]);
        for (int i = 0; i < 4; i++)
            k[i] = (sel >= 5'd12 && sel <= 5'd15) ? kchan(lo, hi, sel[1:0], 2'(i)) : v;
        return k;
    endfunction

    assign st = cfg.setup;
    assign ras = cfg.raster;

    // select inputs for the three color channels and alpha
    always_comb
    begin
        kc = kvec(st[48:44], cfg.konst_lo, cfg.konst_hi);
        ka = kvec(st[53:49], cfg.konst_lo, cfg.konst_hi);
        kon = {ka[3], kc[2], kc[1], kc[0]};
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                logic [3:0] sel;
                sel = st[i*4 +: 4];
                if (sel < tcfs_pkg::CSEL_TEX_C)
                    carg[ch][i] = in_pix.regs[sel[2:1]][sel[0] ? 3 : ch];
                else
                begin
                    case (sel)
                        tcfs_pkg::CSEL_TEX_C: carg[ch][i] = 11'({3'd0, in_pix.tex[ch]});
                        tcfs_pkg::CSEL_TEX_A: carg[ch][i] = 11'({3'd0, in_pix.tex[3]});
                        tcfs_pkg::CSEL_RAS_C: carg[ch][i] = 11'({3'd0, ras[ch]});
                        tcfs_pkg::CSEL_RAS_A: carg[ch][i] = 11'({3'd0, ras[3]});
                        tcfs_pkg::CSEL_ONE:   carg[ch][i] = 11'sd255;
                        tcfs_pkg::CSEL_HALF:  carg[ch][i] = 11'sd128;
                        tcfs_pkg::CSEL_KONST: carg[ch][i] = 11'({3'd0, kon[ch]});
                        default:              carg[ch][i] = '0;
                    endcase
                end
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            logic [2:0] asel;
            asel = st[24 + i*3 +: 3];
            if (asel < tcfs_pkg::ASEL_TEX)
                aarg[i] = in_pix.regs[asel[1:0]][3];
            else
            begin
                case (asel)
                    tcfs_pkg::ASEL_TEX:   aarg[i] = 11'({3'd0, in_pix.tex[3]});
                    tcfs_pkg::ASEL_RAS:   aarg[i] = 11'({3'd0, ras[3]});
                    tcfs_pkg::ASEL_KONST: aarg[i] = 11'({3'd0, kon[3]});
                    default:              aarg[i] = '0;
                endcase
            end
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_color
        tcfs_combine u_comb (
            .sub(st[16]), .bias(st[18:17]), .scale(st[20:19]), .clamp8(st[21]),
            .a(carg[ch][0]), .b(carg[ch][1]), .c(carg[ch][2]), .d(carg[ch][3]),
            .res(cres[ch])
        );
    end

    tcfs_combine u_alpha (
        .sub(st[36]), .bias(st[38:37]), .scale(st[40:39]), .clamp8(st[41]),
        .a(aarg[0]), .b(aarg[1]), .c(aarg[2]), .d(aarg[3]),
        .res(ares)
    );

    // write destinations, color before alpha; bypass when stage is off
    always_comb
    begin
        pix_next = in_pix;
        if (cfg.enable)
        begin
            for (int ch = 0; ch < 3; ch++)
                pix_next.regs[st[23:22]][ch] = cres[ch];
            pix_next.regs[st[43:42]][3] = ares;
            pix_next.lastc = st[23:22];
            pix_next.lasta = st[43:42];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            pix_reg <= pix_next;
    end

    assign out_valid = valid_reg;
    assign out_pix = pix_reg;

endmodule
